// File: design/acsi_pkg.sv
// Shared types, codes and constants for the CSI escape sequence parser.
`default_nettype none

package acsi_pkg;

  localparam int MAX_PARAMS_DEF  = 8;
  localparam int PARAM_WIDTH_DEF = 16;

  localparam int RESULT_CAP  = 8;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 16;
  localparam int QUEUE_DEPTH = 4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PASS    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ESCAPE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNIMPL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINAL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

  // Character codes and class bounds
  localparam logic [BYTE_W-1:0] BYTE_ESC  = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_CSI  = 8'h5B;
  localparam logic [BYTE_W-1:0] BYTE_SEP  = 8'h3B;
  localparam logic [BYTE_W-1:0] PARAM_LO  = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI  = 8'h39;
  localparam logic [BYTE_W-1:0] PARAM_HI  = 8'h3F;
  localparam logic [BYTE_W-1:0] INTER_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] INTER_HI  = 8'h2F;
  localparam logic [BYTE_W-1:0] FINAL_LO  = 8'h40;
  localparam logic [BYTE_W-1:0] FINAL_HI  = 8'h7E;

  // One classified request from the front end to the result stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   char_out;
    logic [BYTE_W-1:0]   command;
    logic [CNT_W-1:0]    count;
  } job_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// File: design/acsi_queue.sv
// Short request queue between the classifier and the result stage.
`default_nettype none

module acsi_queue import acsi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PTR_W+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q <= (PTR_W+1)'(QUEUE_DEPTH) && cnt_q != '0)
    else $error("queue count out of range after push");

endmodule

`default_nettype wire

// File: design/acsi_front.sv
// Front end: accepts bytes, tracks the parse mode and accumulates parameters.
`default_nettype none

module acsi_front import acsi_pkg::*; #(
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [BYTE_W-1:0]             byte_in_i,
  output logic                               push_o,
  output job_t                               job_o,
  input  wire logic                          q_full_i,
  input  wire logic                          final_done_i,
  output logic                               st_clear_o,
  output logic                               st_we_o,
  output logic [idx_w(MAX_PARAMS)-1:0]       st_addr_o,
  output logic [PARAM_WIDTH-1:0]             st_data_o
);

  localparam int SW       = $clog2(MAX_PARAMS + 1);
  localparam int IW       = idx_w(MAX_PARAMS);
  localparam int USED_CAP = (MAX_PARAMS < RESULT_CAP) ? MAX_PARAMS : RESULT_CAP;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_PARAM = 2'd2;
  localparam logic [1:0] MODE_INTER = 2'd3;

  logic [1:0]             mode_q, mode_d;
  logic [SW-1:0]          slot_q, slot_d;
  logic [PARAM_WIDTH-1:0] acc_q, acc_d;
  logic                   pend_q, pend_d;

  logic                   accept;
  logic                   slot_ok;
  logic                   in_param, is_digit, is_inter, is_final;
  logic [PARAM_WIDTH+3:0] prod;
  logic [PARAM_WIDTH-1:0] acc_sat;
  logic [CNT_W-1:0]       used;

  // Hold input while the queue is full or a finished sequence is still being read out of the store
  assign in_stall_o = q_full_i || (mode_q == MODE_IDLE && pend_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_ok    = slot_q < SW'(MAX_PARAMS);

  assign in_param = byte_in_i >= PARAM_LO && byte_in_i <= PARAM_HI;
  assign is_digit = byte_in_i >= PARAM_LO && byte_in_i <= DIGIT_HI;
  assign is_inter = byte_in_i >= INTER_LO && byte_in_i <= INTER_HI;
  assign is_final = byte_in_i >= FINAL_LO && byte_in_i <= FINAL_HI;

  // acc * 10 + digit, saturating
  assign prod    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + (PARAM_WIDTH+4)'(byte_in_i[3:0]);
  assign acc_sat = (|prod[PARAM_WIDTH+3:PARAM_WIDTH]) ? '1 : prod[PARAM_WIDTH-1:0];

  assign used = (slot_q >= SW'(USED_CAP)) ? CNT_W'(USED_CAP)
                                          : CNT_W'(slot_q) + CNT_W'(1);

  assign st_addr_o = slot_q[IW-1:0];
  assign st_data_o = acc_q;

  always_comb begin
    mode_d         = mode_q;
    slot_d         = slot_q;
    acc_d          = acc_q;
    pend_d         = pend_q;
    push_o         = 1'b0;
    st_clear_o     = 1'b0;
    st_we_o        = 1'b0;
    job_o.status   = ST_ESCAPE;
    job_o.char_out = '0;
    job_o.command  = '0;
    job_o.count    = CNT_W'(1);

    if (final_done_i) begin
      pend_d = 1'b0;
    end

    if (accept) begin
      push_o = 1'b1;
      unique case (mode_q) inside
        MODE_IDLE: begin
          if (byte_in_i == BYTE_ESC) begin
            mode_d     = MODE_ESC;
            slot_d     = '0;
            acc_d      = '0;
            st_clear_o = 1'b1;
          end else begin
            job_o.status   = ST_PASS;
            job_o.char_out = byte_in_i;
          end
        end
        MODE_ESC: begin
          if (byte_in_i == BYTE_CSI) begin
            mode_d = MODE_PARAM;
          end else begin
            job_o.status = ST_UNIMPL;
          end
        end
        MODE_PARAM, MODE_INTER: begin
          if (mode_q == MODE_PARAM && in_param) begin
            if (is_digit && slot_ok) begin
              acc_d = acc_sat;
            end else if (byte_in_i == BYTE_SEP && slot_ok) begin
              // commit the current slot and advance
              st_we_o = 1'b1;
              slot_d  = slot_q + SW'(1);
              acc_d   = '0;
            end
          end else begin
            mode_d = MODE_INTER;
            if (is_inter) begin
              job_o.status = ST_ESCAPE;
            end else if (is_final) begin
              mode_d        = MODE_IDLE;
              st_we_o       = slot_ok;
              pend_d        = 1'b1;
              job_o.status  = ST_FINAL;
              job_o.command = byte_in_i;
              job_o.count   = used;
            end else begin
              job_o.status = ST_INVALID;
            end
          end
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      slot_q <= '0;
      acc_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      slot_q <= slot_d;
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_clear_o || st_we_o) |-> !pend_q)
    else $error("parameter store changed while a burst is pending");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("request pushed into a full queue");

endmodule

`default_nettype wire

// File: design/acsi_back.sv
// Result stage: parameter store and output register, expands final requests.
`default_nettype none

module acsi_back import acsi_pkg::*; #(
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire job_t                          head_i,
  input  wire logic                          head_valid_i,
  output logic                               pop_o,
  output logic                               final_done_o,
  input  wire logic                          st_clear_i,
  input  wire logic                          st_we_i,
  input  wire logic [idx_w(MAX_PARAMS)-1:0]  st_addr_i,
  input  wire logic [PARAM_WIDTH-1:0]        st_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [STATUS_W-1:0]                status_o,
  output logic [BYTE_W-1:0]                  char_out_o,
  output logic [BYTE_W-1:0]                  command_o,
  output logic [IDX_W-1:0]                   param_index_o,
  output logic [VALUE_W-1:0]                 param_value_o,
  output logic                               last_o
);

  localparam int IW = idx_w(MAX_PARAMS);

  logic [PARAM_WIDTH-1:0] store_q [MAX_PARAMS];
  logic [MAX_PARAMS-1:0]  vld_q;

  logic [IDX_W-1:0]       idx_q;
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [BYTE_W-1:0]      char_q;
  logic [BYTE_W-1:0]      cmd_q;
  logic [IDX_W-1:0]       pidx_q;
  logic [VALUE_W-1:0]     pval_q;
  logic                   last_q;

  logic                   ld;
  logic                   emit;
  logic                   is_final;
  logic                   is_last_part;
  logic [IW-1:0]          rd_addr;
  logic [PARAM_WIDTH-1:0] rd_val;

  assign ld           = !out_valid_q || !out_stall_i;
  assign emit         = head_valid_i && ld;
  assign is_final     = head_i.status == ST_FINAL;
  assign is_last_part = ({1'b0, idx_q} + CNT_W'(1)) == head_i.count;
  assign pop_o        = emit && (!is_final || is_last_part);
  assign final_done_o = emit && is_final && is_last_part;

  assign rd_addr = IW'(idx_q);
  assign rd_val  = vld_q[rd_addr] ? store_q[rd_addr] : '0;

  always_ff @(posedge clk_i) begin
    if (st_we_i) begin
      store_q[st_addr_i] <= st_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_clear_i) begin
        vld_q <= '0;
      end else if (st_we_i) begin
        vld_q[st_addr_i] <= 1'b1;
      end
      if (ld) begin
        out_valid_q <= head_valid_i;
      end
      // advance through the slots of a final request
      if (emit && is_final) begin
        idx_q <= is_last_part ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= head_i.status;
      char_q   <= head_i.char_out;
      cmd_q    <= head_i.command;
      pidx_q   <= is_final ? idx_q : '0;
      pval_q   <= is_final ? VALUE_W'(rd_val) : '0;
      last_q   <= !is_final || is_last_part;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign char_out_o    = char_q;
  assign command_o     = cmd_q;
  assign param_index_o = pidx_q;
  assign param_value_o = pval_q;
  assign last_o        = last_q;

  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && is_final |-> {1'b0, idx_q} < head_i.count)
    else $error("burst index beyond parameter count");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_FINAL |-> last_q)
    else $error("single result without last flag");

endmodule

`default_nettype wire

// File: design/ansi_csi_escape_parser.sv
// Top level: CSI escape sequence parser with classifier, queue and result stage.
// A result is registered in the queue and then in the output register.
// Throughput: one byte per cycle while the queue has room; a final byte yields 1..8
//   results, one per cycle unless stalled; later bytes wait until all are read out.
// Reset (async, active low) sets idle mode, slot zero, empties the queue and
//   the output register and marks every parameter slot as zero.
`default_nettype none

module ansi_csi_escape_parser import acsi_pkg::*; #(
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [BYTE_W-1:0]    byte_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [BYTE_W-1:0]         char_out_o,
  output logic [BYTE_W-1:0]         command_o,
  output logic [IDX_W-1:0]          param_index_o,
  output logic [VALUE_W-1:0]        param_value_o,
  output logic                      last_o
);

  localparam int IW = idx_w(MAX_PARAMS);

  logic                   push;
  job_t                   job_in;
  job_t                   job_head;
  logic                   q_empty;
  logic                   q_full;
  logic                   pop;
  logic                   final_done;
  logic                   st_clear;
  logic                   st_we;
  logic [IW-1:0]          st_addr;
  logic [PARAM_WIDTH-1:0] st_data;

  acsi_front #(
    .MAX_PARAMS  (MAX_PARAMS),
    .PARAM_WIDTH (PARAM_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .push_o       (push),
    .job_o        (job_in),
    .q_full_i     (q_full),
    .final_done_i (final_done),
    .st_clear_o   (st_clear),
    .st_we_o      (st_we),
    .st_addr_o    (st_addr),
    .st_data_o    (st_data)
  );

  acsi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  acsi_back #(
    .MAX_PARAMS  (MAX_PARAMS),
    .PARAM_WIDTH (PARAM_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (job_head),
    .head_valid_i  (!q_empty),
    .pop_o         (pop),
    .final_done_o  (final_done),
    .st_clear_i    (st_clear),
    .st_we_i       (st_we),
    .st_addr_i     (st_addr),
    .st_data_i     (st_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .char_out_o    (char_out_o),
    .command_o     (command_o),
    .param_index_o (param_index_o),
    .param_value_o (param_value_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// File: verif/acsi_result_checker.sv
// Checker for the CSI parser: tracks parser state from accepted requests and checks every result.
module acsi_result_checker import acsi_pkg::*; #(
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_stall_i,
  input  logic [BYTE_W-1:0]   req_byte_i,
  input  logic                res_valid_i,
  input  logic                res_stall_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [BYTE_W-1:0]   char_out_i,
  input  logic [BYTE_W-1:0]   command_i,
  input  logic [IDX_W-1:0]    param_index_i,
  input  logic [VALUE_W-1:0]  param_value_i,
  input  logic                last_i,
  output int                  error_count_o,
  output int                  awaiting_o
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_ESC, MODE_PARAM, MODE_INTER} csi_mode_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   char_out;
    logic [BYTE_W-1:0]   command;
    logic [IDX_W-1:0]    index;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } csi_result_t;

  localparam longint unsigned VALUE_CEIL = (64'd1 << PARAM_WIDTH) - 64'd1;
  localparam int              SW         = $clog2(MAX_PARAMS + 1);
  localparam int              IW         = idx_w(MAX_PARAMS);

  csi_mode_e              mode;
  logic [PARAM_WIDTH-1:0] slot_values [MAX_PARAMS];
  logic [SW-1:0]          slot;
  logic [BYTE_W-1:0]      command_byte;
  csi_result_t            awaited_results [$];
  int                     mismatches    = 0;
  int                     waiting_count = 0;

  assign error_count_o = mismatches;
  assign awaiting_o    = waiting_count;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic clear_slots();
    foreach (slot_values[i]) slot_values[i] = '0;
    slot         = '0;
    command_byte = '0;
  endtask

  task automatic push_result(input logic [STATUS_W-1:0] status, input logic [BYTE_W-1:0] ch,
                             input logic [BYTE_W-1:0] cmd, input int index,
                             input logic [VALUE_W-1:0] value, input logic last);
    csi_result_t r;
    r.status   = status;
    r.char_out = ch;
    r.command  = cmd;
    r.index    = IDX_W'(index);
    r.value    = value;
    r.last     = last;
    awaited_results.push_back(r);
  endtask

  // Advance the parser state by one byte and queue the results it causes.
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    longint unsigned grown;
    int              used;
    case (mode)
      MODE_IDLE: begin
        if (b == BYTE_ESC) begin
          clear_slots();
          mode = MODE_ESC;
          push_result(ST_ESCAPE, '0, '0, 0, '0, 1'b1);
        end else begin
          push_result(ST_PASS, b, '0, 0, '0, 1'b1);
        end
        return;
      end
      MODE_ESC: begin
        if (b == BYTE_CSI) begin
          mode = MODE_PARAM;
          push_result(ST_ESCAPE, '0, '0, 0, '0, 1'b1);
        end else begin
          push_result(ST_UNIMPL, '0, '0, 0, '0, 1'b1);
        end
        return;
      end
      MODE_PARAM: begin
        if (b >= PARAM_LO && b <= PARAM_HI) begin
          if (b <= DIGIT_HI) begin
            if (slot < SW'(MAX_PARAMS)) begin
              grown = longint'(slot_values[slot[IW-1:0]]) * 10 + longint'(b - PARAM_LO);
              if (grown > VALUE_CEIL) grown = VALUE_CEIL;
              slot_values[slot[IW-1:0]] = PARAM_WIDTH'(grown);
            end
          end else if (b == BYTE_SEP && slot < SW'(MAX_PARAMS)) begin
            slot++;
          end
          push_result(ST_ESCAPE, '0, '0, 0, '0, 1'b1);
          return;
        end
        // fall through and treat the byte as an intermediate-mode byte
        mode = MODE_INTER;
      end
      default: ;
    endcase

    if (b >= INTER_LO && b <= INTER_HI) begin
      push_result(ST_ESCAPE, '0, '0, 0, '0, 1'b1);
    end else if (b >= FINAL_LO && b <= FINAL_HI) begin
      used = int'(slot) + 1;
      if (used > MAX_PARAMS) used = MAX_PARAMS;
      if (used > RESULT_CAP) used = RESULT_CAP;
      command_byte = b;
      mode         = MODE_IDLE;
      for (int k = 0; k < used; k++)
        push_result(ST_FINAL, '0, command_byte, k, VALUE_W'(slot_values[k]), k == used - 1);
    end else begin
      push_result(ST_INVALID, '0, '0, 0, '0, 1'b1);
    end
  endtask

  task automatic check_result();
    csi_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited, status", 32'(status_i), '0);
      return;
    end
    want = awaited_results.pop_front();
    if (status_i !== want.status)
      report_mismatch("status", 32'(status_i), 32'(want.status));
    if (char_out_i !== want.char_out)
      report_mismatch("char_out", 32'(char_out_i), 32'(want.char_out));
    if (command_i !== want.command)
      report_mismatch("command", 32'(command_i), 32'(want.command));
    if (param_index_i !== want.index)
      report_mismatch("param_index", 32'(param_index_i), 32'(want.index));
    if (param_value_i !== want.value)
      report_mismatch("param_value", 32'(param_value_i), 32'(want.value));
    if (last_i !== want.last)
      report_mismatch("last", 32'(last_i), 32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = MODE_IDLE;
      clear_slots();
      awaited_results.delete();
    end else begin
      if (req_valid_i && !req_stall_i) parse_byte(req_byte_i);
      if (res_valid_i && !res_stall_i) check_result();
    end
    waiting_count = awaited_results.size();
  end

endmodule

// File: verif/ansi_csi_escape_parser_tb.sv
// Testbench top for the CSI parser: drives byte requests, stalls results and gives the verdict.
module ansi_csi_escape_parser_tb;
  import acsi_pkg::*;

  localparam int RANDOM_BYTES = 500;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic [BYTE_W-1:0]   byte_in   = '0;
  logic                out_stall = 1'b0;
  logic                steady    = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   char_out;
  logic [BYTE_W-1:0]   command;
  logic [IDX_W-1:0]    param_index;
  logic [VALUE_W-1:0]  param_value;
  logic                last;
  int                  errors;
  int                  awaiting;
  int                  cycles = 0;
  int                  sent   = 0;
  bit                  paused = 1'b0;

  // Directed opener: byte extremes, unimplemented escape, saturation, private
  // marker, intermediate, invalid byte, and a sequence with too many separators.
  logic [BYTE_W-1:0] opening [$] = '{
    8'h00, 8'hFF, BYTE_ESC, 8'h41, BYTE_CSI,
    8'h37, 8'h30, 8'h30, 8'h30, 8'h30, BYTE_SEP, PARAM_HI, INTER_HI, 8'h7F, FINAL_LO,
    BYTE_ESC, BYTE_CSI, BYTE_SEP, BYTE_SEP, BYTE_SEP, BYTE_SEP,
    BYTE_SEP, BYTE_SEP, BYTE_SEP, BYTE_SEP, 8'h31, FINAL_HI
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ansi_csi_escape_parser i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .byte_in_i     (byte_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .char_out_o    (char_out),
    .command_o     (command),
    .param_index_o (param_index),
    .param_value_o (param_value),
    .last_o        (last)
  );

  acsi_result_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (in_valid),
    .req_stall_i   (in_stall),
    .req_byte_i    (byte_in),
    .res_valid_i   (out_valid),
    .res_stall_i   (out_stall),
    .status_i      (status),
    .char_out_i    (char_out),
    .command_i     (command),
    .param_index_i (param_index),
    .param_value_i (param_value),
    .last_i        (last),
    .error_count_o (errors),
    .awaiting_o    (awaiting)
  );

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one byte, idling at random first, and return right after it is accepted.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!steady) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sent++;
  endtask

  // Build one control sequence with random parameters; optionally spoil it.
  task automatic send_csi(input bit broken);
    logic [BYTE_W-1:0] seq [$];
    int                seps;
    int                digits;
    seq.push_back(BYTE_ESC);
    if ($urandom_range(9) == 0) seq.push_back(BYTE_W'($urandom_range(255)));
    seq.push_back(BYTE_CSI);
    seps = ($urandom_range(5) == 0) ? $urandom_range(10) : $urandom_range(3);
    for (int i = 0; i <= seps; i++) begin
      digits = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(3);
      repeat (digits) seq.push_back(BYTE_W'(PARAM_LO + $urandom_range(9)));
      if ($urandom_range(19) == 0) seq.push_back(BYTE_W'(BYTE_SEP + $urandom_range(1, 4)));
      if (i < seps) seq.push_back(BYTE_SEP);
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) seq.push_back(BYTE_W'(INTER_LO + $urandom_range(15)));
    seq.push_back(BYTE_W'(FINAL_LO + $urandom_range(62)));
    if (broken) begin
      if ($urandom_range(1) == 0) void'(seq.pop_back());
      else seq.insert($urandom_range(seq.size() - 1), BYTE_W'($urandom_range(255)));
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      steady <= (sent >= 120 && sent < 220);
      // drain everything once before going on
      if (!paused && sent >= 300) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 60) send_csi(1'b0);
      else if (pick < 80) repeat ($urandom_range(1, 8)) send_byte(BYTE_W'($urandom_range(255)));
      else if (pick < 90) send_csi(1'b1);
      else send_byte(BYTE_W'($urandom_range(255)));
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (16) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
